>>> rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Shared sizes, operation codes and request and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package psa_pkg;

    localparam int POOL_DEPTH   = 64;
    localparam int HANDLE_WIDTH = 32;
    localparam int IDX_W        = $clog2(POOL_DEPTH);
    localparam int SIZE_W       = IDX_W + 1;
    localparam int OP_W         = 3;

    localparam logic [OP_W-1:0] OP_ALLOC   = 3'd0;
    localparam logic [OP_W-1:0] OP_READ    = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [IDX_W-1:0]        slot_index;
        logic [IDX_W-1:0]        start_index;
        logic [HANDLE_WIDTH-1:0] new_handle;
    } req_t;

    typedef struct packed {
        logic                    success;
        logic [IDX_W-1:0]        found_index;
        logic [HANDLE_WIDTH-1:0] handle_out;
    } rsp_t;

endpackage

`default_nettype wire

>>> rtl/pool_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// Slot pool allocator
// Busy flags with a rotating search and a handle table held in RAM.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge where start is high and busy is low.
// The request carries an operation, a slot index, a search start index and
// a new handle. Busy is high in the execute cycle, the cycle after a request
// is taken, so no new request is taken while the last one executes. Every
// request gives exactly one result on rsp, marked by a one-cycle done strobe
// registered at the end of the execute cycle. The accept cycle reads the
// handle RAM; the execute cycle runs the free-slot search over the busy
// flags, updates the flags and writes the RAM. The user must write the pool
// size through cfg_we and cfg_data only while no request is in flight; the
// block does not enforce this. Reset frees every slot, clears the pool size
// and marks every handle as zero through per-slot written bits, so the block
// is ready once reset ends. The receiver cannot stall the result; done is high for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pool_slot_allocator_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire psa_pkg::req_t               req,
    output logic                             done,
    output psa_pkg::rsp_t                    rsp,
    input  wire logic                        cfg_we,
    input  wire logic [psa_pkg::SIZE_W-1:0]  cfg_data
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [psa_pkg::SIZE_W-1:0]         pool_size_reg, pool_size_next;
    logic [psa_pkg::POOL_DEPTH-1:0]     flags_reg, flags_next;
    logic [psa_pkg::POOL_DEPTH-1:0]     written_reg, written_next;
    psa_pkg::req_t                      req_reg, req_next;
    psa_pkg::rsp_t                      rsp_reg, rsp_next;

    logic                               accept;
    logic [psa_pkg::SIZE_W-1:0]         live_n;
    logic [psa_pkg::POOL_DEPTH-1:0]     range_vec;
    logic [psa_pkg::POOL_DEPTH-1:0]     free_vec;
    logic                               in_range;
    logic                               srch_found;
    logic [psa_pkg::IDX_W-1:0]          srch_idx;
    logic                               ram_we;
    logic [psa_pkg::HANDLE_WIDTH-1:0]   ram_rdata;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    assign live_n = (pool_size_reg > psa_pkg::SIZE_W'(psa_pkg::POOL_DEPTH))
                  ? psa_pkg::SIZE_W'(psa_pkg::POOL_DEPTH) : pool_size_reg;
    assign in_range = {1'b0, req_reg.slot_index} < live_n;

    always_comb
    begin
        for (int i = 0; i < psa_pkg::POOL_DEPTH; i++)
        begin
            range_vec[i] = psa_pkg::SIZE_W'(i) < live_n;
        end
    end

    assign free_vec = ~flags_reg & range_vec;

    psa_search u_search (
        .free_vec  (free_vec),
        .start_idx (req_reg.start_index),
        .found     (srch_found),
        .found_idx (srch_idx)
    );

    // The RAM is read in the cycle a request is taken and written only in the
    // following cycle, so a read and a write never meet on one entry.
    psa_ram #(
        .WIDTH (psa_pkg::HANDLE_WIDTH),
        .DEPTH (psa_pkg::POOL_DEPTH)
    ) u_handle_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (req_reg.slot_index),
        .wdata (req_reg.new_handle),
        .raddr (req.slot_index),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        busy_next      = accept;
        done_next      = busy_reg;
        pool_size_next = cfg_we ? cfg_data : pool_size_reg;
        req_next       = accept ? req : req_reg;
        flags_next     = flags_reg;
        written_next   = written_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        if (busy_reg)
        begin
            rsp_next = '0;
            case (req_reg.operation)
                psa_pkg::OP_ALLOC:
                begin
                    if (srch_found)
                    begin
                        rsp_next.success     = 1'b1;
                        rsp_next.found_index = srch_idx;
                        flags_next[srch_idx] = 1'b1;
                    end
                end
                psa_pkg::OP_READ:
                begin
                    if (in_range)
                    begin
                        rsp_next.success = 1'b1;
                        if (written_reg[req_reg.slot_index])
                        begin
                            rsp_next.handle_out = ram_rdata;
                        end
                    end
                end
                psa_pkg::OP_RELEASE:
                begin
                    if (in_range)
                    begin
                        rsp_next.success               = 1'b1;
                        flags_next[req_reg.slot_index] = 1'b0;
                    end
                end
                psa_pkg::OP_REMOVE:
                begin
                    if (in_range)
                    begin
                        rsp_next.success               = 1'b1;
                        flags_next[req_reg.slot_index] = 1'b1;
                    end
                end
                psa_pkg::OP_REPLACE:
                begin
                    if (in_range)
                    begin
                        rsp_next.success                 = 1'b1;
                        flags_next[req_reg.slot_index]   = 1'b0;
                        written_next[req_reg.slot_index] = 1'b1;
                        ram_we                           = 1'b1;
                    end
                end
                default:
                begin
                    rsp_next.success = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            pool_size_reg <= '0;
            flags_reg     <= '0;
            written_reg   <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            pool_size_reg <= pool_size_next;
            flags_reg     <= flags_next;
            written_reg   <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

`ifndef ASSERT_OFF
    a_done_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("result strobe without an executed request");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> !busy_reg)
        else $error("request held longer than one execute cycle");

    a_alloc_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.success && (req_reg.operation == psa_pkg::OP_ALLOC))
        |-> flags_reg[rsp_reg.found_index])
        else $error("allocated slot not marked busy");
`endif

endmodule

`default_nettype wire

>>> rtl/psa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/psa_search.sv
// ----------------------------------------------------------------------------
// Rotating free-slot search
// Finds the lowest free slot at or above the start index, else the lowest.
// ----------------------------------------------------------------------------
`default_nettype none

module psa_search (
    input  wire logic [psa_pkg::POOL_DEPTH-1:0] free_vec,
    input  wire logic [psa_pkg::IDX_W-1:0]      start_idx,
    output logic                                found,
    output logic      [psa_pkg::IDX_W-1:0]      found_idx
);

    function automatic logic [psa_pkg::IDX_W-1:0] lowest(
        input logic [psa_pkg::POOL_DEPTH-1:0] v
    );
        logic [psa_pkg::IDX_W-1:0] r;
        r = '0;
        for (int i = psa_pkg::POOL_DEPTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = psa_pkg::IDX_W'(i);
            end
        end
        return r;
    endfunction

    logic [psa_pkg::POOL_DEPTH-1:0] upper_vec;

    always_comb
    begin
        for (int i = 0; i < psa_pkg::POOL_DEPTH; i++)
        begin
            upper_vec[i] = free_vec[i] && (psa_pkg::IDX_W'(i) >= start_idx);
        end
        found = |free_vec;
        if (|upper_vec)
        begin
            found_idx = lowest(upper_vec);
        end
        else
        begin
            found_idx = lowest(free_vec);
        end
    end

endmodule

`default_nettype wire
